>>> hw/rtl/wwr_pkg.sv
// Package for the whole-word replace stream block.
// Holds the configuration register codes, the command queue entry and the front states.
// No dependencies.
package wwr_pkg;

	localparam int CFG_W     = 64;
	localparam int LEN_W     = 5;
	localparam int CFG_IDX_W = 3;
	localparam int BYTE_W    = 8;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEARCH_LOW   = 3'd0,
		REG_SEARCH_HIGH  = 3'd1,
		REG_SEARCH_LEN   = 3'd2,
		REG_REPLACE_LOW  = 3'd3,
		REG_REPLACE_HIGH = 3'd4,
		REG_REPLACE_LEN  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] search_low;
		logic [CFG_W-1:0] search_high;
		logic [LEN_W-1:0] search_len;
		logic [CFG_W-1:0] replace_low;
		logic [CFG_W-1:0] replace_high;
		logic [LEN_W-1:0] replace_len;
	} cfg_regs_t;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_REPL,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [BYTE_W-1:0] data;
		logic              last;
	} cmd_t;

	typedef enum logic {
		FR_RUN,
		FR_FLUSH
	} front_state_t;

	function automatic logic word_char(input logic [BYTE_W-1:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h61 && c <= 8'h7a);
	endfunction

endpackage

>>> hw/rtl/wwr_fifo.sv
// Short command queue between the front and the back of the replace block.
// Depends on wwr_pkg for the command entry type.
module wwr_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wwr_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output wwr_pkg::cmd_t pop_data,
	output logic          empty
);
	import wwr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/wwr_front.sv
// Front part of the replace block: accepts text bytes, keeps the lookahead window
// and decides at its head whether a whole-word match starts there.
// Depends on wwr_pkg; feeds commands to wwr_fifo.
module wwr_front #(
	parameter int MAX_WORD = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wwr_pkg::cfg_regs_t  cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                end_of_text,
	output logic                q_push,
	output wwr_pkg::cmd_t       q_data,
	input  logic                q_full
);
	import wwr_pkg::*;

	localparam int DEPTH = MAX_WORD + 1;
	localparam int CNT_W = $clog2(MAX_WORD + 2);

	front_state_t      state_q, state_d;
	logic [BYTE_W-1:0] win_q [DEPTH];
	logic [BYTE_W-1:0] win_d [DEPTH];
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [BYTE_W-1:0] before_q, before_d;
	logic              in_stream_q, in_stream_d;
	logic [BYTE_W-1:0] latch_q [MAX_WORD];
	logic [CNT_W-1:0]  latch_len_q, latch_len_d;
	logic              latch_load;

	logic [2*CFG_W-1:0]      search_vec;
	logic [CNT_W-1:0]        cfg_len;
	logic [CNT_W-1:0]        eff_len;
	logic [BYTE_W-1:0]       eff_word [MAX_WORD];
	logic [BYTE_W-1:0]       view [DEPTH];
	logic [DEPTH*BYTE_W-1:0] view_vec;
	logic [DEPTH*BYTE_W-1:0] shifted;
	logic [CNT_W-1:0]        view_cnt;
	logic [BYTE_W-1:0]       after_byte;
	logic [BYTE_W-1:0]       tail_byte;
	logic                    match;
	logic                    hit;
	logic                    at_end;
	logic                    accept;
	logic                    do_decide;
	logic [CNT_W-1:0]        drop;

	assign search_vec = {cfg.search_high, cfg.search_low};
	assign cfg_len    = (cfg.search_len > LEN_W'(MAX_WORD)) ? CNT_W'(MAX_WORD)
		: CNT_W'(cfg.search_len);
	assign eff_len    = in_stream_q ? latch_len_q : cfg_len;
	assign in_ready   = (state_q == FR_RUN) && !q_full;
	assign accept     = in_valid && in_ready;
	assign at_end     = (state_q == FR_FLUSH);
	assign view_cnt   = at_end ? cnt_q : cnt_q + 1'b1;
	assign latch_load = accept && !in_stream_q;

	always_comb begin
		for (int i = 0; i < MAX_WORD; i++) begin
			eff_word[i] = in_stream_q ? latch_q[i] : search_vec[i*BYTE_W +: BYTE_W];
		end
		for (int i = 0; i < DEPTH; i++) begin
			view[i] = (!at_end && CNT_W'(i) == cnt_q) ? in_byte : win_q[i];
			view_vec[i*BYTE_W +: BYTE_W] = view[i];
		end
	end

	always_comb begin
		match      = 1'b1;
		after_byte = '0;
		tail_byte  = '0;
		for (int i = 0; i < MAX_WORD; i++) begin
			if (CNT_W'(i) < eff_len && view[i] != eff_word[i]) begin
				match = 1'b0;
			end
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (CNT_W'(i) == eff_len) begin
				after_byte = view[i];
			end
			if (CNT_W'(i + 1) == eff_len) begin
				tail_byte = view[i];
			end
		end
		hit = (eff_len != '0) && (view_cnt >= eff_len) && !word_char(before_q) && match &&
			((view_cnt == eff_len) ? at_end : !word_char(after_byte));
	end

	assign drop    = hit ? eff_len : CNT_W'(1);
	assign shifted = view_vec >> {drop, 3'b000};

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		before_d    = before_q;
		in_stream_d = in_stream_q;
		latch_len_d = latch_len_q;
		q_push      = 1'b0;
		q_data      = '{kind: CMD_BYTE, data: view[0], last: !at_end};
		do_decide   = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			win_d[i] = win_q[i];
		end
		if (latch_load) begin
			in_stream_d = 1'b1;
			latch_len_d = cfg_len;
		end
		case (state_q)
			FR_RUN: begin
				if (accept) begin
					do_decide = !end_of_text && (view_cnt > eff_len);
					if (end_of_text) begin
						state_d = FR_FLUSH;
					end
				end
			end
			FR_FLUSH: begin
				if (!q_full) begin
					if (cnt_q != '0) begin
						do_decide = 1'b1;
					end else begin
						q_push      = 1'b1;
						q_data      = '{kind: CMD_END, data: '0, last: 1'b1};
						before_d    = '0;
						in_stream_d = 1'b0;
						latch_len_d = '0;
						state_d     = FR_RUN;
					end
				end
			end
			default: begin
				state_d = FR_RUN;
			end
		endcase
		if (accept || do_decide) begin
			cnt_d = view_cnt;
			for (int i = 0; i < DEPTH; i++) begin
				win_d[i] = view[i];
			end
		end
		if (do_decide) begin
			q_push      = 1'b1;
			q_data.kind = hit ? CMD_REPL : CMD_BYTE;
			before_d    = hit ? tail_byte : view[0];
			cnt_d       = view_cnt - drop;
			for (int i = 0; i < DEPTH; i++) begin
				win_d[i] = shifted[i*BYTE_W +: BYTE_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			win_q[i] <= win_d[i];
		end
		if (latch_load) begin
			for (int i = 0; i < MAX_WORD; i++) begin
				latch_q[i] <= search_vec[i*BYTE_W +: BYTE_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FR_RUN;
			cnt_q       <= '0;
			before_q    <= '0;
			in_stream_q <= 1'b0;
			latch_len_q <= '0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			before_q    <= before_d;
			in_stream_q <= in_stream_d;
			latch_len_q <= latch_len_d;
		end
	end

endmodule

>>> hw/rtl/wwr_back.sv
// Back part of the replace block: carries out queued commands, expands a
// replacement into its bytes and holds the result in the output register.
// Depends on wwr_pkg; reads commands from wwr_fifo.
module wwr_back #(
	parameter int MAX_WORD = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wwr_pkg::cfg_regs_t cfg,
	input  logic               q_empty,
	input  wwr_pkg::cmd_t      q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               has_byte,
	output logic               last_of_run
);
	import wwr_pkg::*;

	localparam int LW    = $clog2(MAX_WORD + 1);
	localparam int IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

	logic [2*CFG_W-1:0] rep_vec;
	logic [BYTE_W-1:0]  rep_bytes [MAX_WORD];
	logic [LW-1:0]      rl;
	cmd_t               cur_q;
	logic               cur_valid_q;
	logic [IDX_W-1:0]   idx_q;
	logic               produce;
	logic               fin;
	logic               advance;
	logic               consume;
	logic [BYTE_W-1:0]  res_byte;
	logic               res_has;
	logic               res_last;

	assign rep_vec = {cfg.replace_high, cfg.replace_low};
	assign rl      = (cfg.replace_len > LEN_W'(MAX_WORD)) ? LW'(MAX_WORD) : LW'(cfg.replace_len);

	always_comb begin
		for (int i = 0; i < MAX_WORD; i++) begin
			rep_bytes[i] = rep_vec[i*BYTE_W +: BYTE_W];
		end
	end

	always_comb begin
		produce  = 1'b0;
		fin      = 1'b1;
		res_byte = cur_q.data;
		res_has  = 1'b1;
		res_last = cur_q.last;
		case (cur_q.kind)
			CMD_BYTE: begin
				produce = cur_valid_q;
			end
			CMD_REPL: begin
				if (rl != '0) begin
					produce  = cur_valid_q;
					fin      = (LW'(idx_q) == rl - 1'b1);
					res_byte = rep_bytes[idx_q];
					res_last = cur_q.last && fin;
				end
			end
			CMD_END: begin
				produce  = cur_valid_q;
				res_byte = '0;
				res_has  = 1'b0;
				res_last = 1'b1;
			end
			default: begin
				produce = 1'b0;
			end
		endcase
	end

	assign advance = !out_valid || out_ready;
	assign consume = cur_valid_q && fin && (!produce || advance);
	assign q_pop   = !q_empty && (!cur_valid_q || consume);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (produce && advance) begin
			out_byte    <= res_byte;
			has_byte    <= res_has;
			last_of_run <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
			end else if (consume) begin
				cur_valid_q <= 1'b0;
			end
			if (consume) begin
				idx_q <= '0;
			end else if (produce && advance) begin
				idx_q <= idx_q + 1'b1;
			end
			if (produce && advance) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/whole_word_replace_stream.sv
// Top level of the whole-word find and replace stream block.
// Holds the configuration registers and joins wwr_front, wwr_fifo and wwr_back.
// Depends on wwr_pkg.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+--------------------------------------
//  in      | in_valid / in_ready    | in_byte, end_of_text
//  out     | out_valid / out_ready  | out_byte, has_byte, last_of_run
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A text byte is taken every cycle while the command queue has room and no flush
// runs; the front makes at most one decision per byte, so replacement bursts of up
// to MAX_WORD bytes are spread by the back at one result per cycle while not stalled.
// After a final byte the input stays closed while the front decides on the pending
// window, a replaced word being a single decision, and then queues the end marker.
// Reset clears the configuration registers, the window count, the boundary byte, the queue and the output valid flag.
// A stalled output fills the four-entry queue and then lowers in_ready.
module whole_word_replace_stream #(
	parameter int MAX_WORD = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        has_byte,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import wwr_pkg::*;

	cfg_regs_t cfg_q;
	logic      q_push;
	cmd_t      q_push_data;
	logic      q_full;
	logic      q_pop;
	cmd_t      q_pop_data;
	logic      q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEARCH_LOW:   cfg_q.search_low   <= cfg_data;
				REG_SEARCH_HIGH:  cfg_q.search_high  <= cfg_data;
				REG_SEARCH_LEN:   cfg_q.search_len   <= cfg_data[LEN_W-1:0];
				REG_REPLACE_LOW:  cfg_q.replace_low  <= cfg_data;
				REG_REPLACE_HIGH: cfg_q.replace_high <= cfg_data;
				REG_REPLACE_LEN:  cfg_q.replace_len  <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	wwr_front #(
		.MAX_WORD(MAX_WORD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.q_push     (q_push),
		.q_data     (q_push_data),
		.q_full     (q_full)
	);

	wwr_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.empty    (q_empty)
	);

	wwr_back #(
		.MAX_WORD(MAX_WORD)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_data     (q_pop_data),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.last_of_run(last_of_run)
	);

`ifndef ASSERT_OFF
	a_flush_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && end_of_text) |=> !in_ready)
		else $error("Input was taken during the flush of a finished stream.");

	a_end_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> (last_of_run && out_byte == 8'd0))
		else $error("End marker without last flag or with a nonzero byte.");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("Command pushed into a full queue.");
`endif

endmodule
